// ===== rtl/core/matrix4_arith_unit_macros.svh =====
// assertion macros shared by the matrix arithmetic rtl
`ifndef MATRIX4_ARITH_UNIT_MACROS_SVH
`define MATRIX4_ARITH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define M4AU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m4au assertion failed");

// next-cycle implication
`define M4AU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m4au assertion failed");

`else

`define M4AU_ASSERT_IMP(label, clk, rst, ante, cons)
`define M4AU_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/m4au_pkg.sv =====
// shared types and constants for the matrix arithmetic unit
package m4au_pkg;

   localparam int DIM       = 4;
   localparam int FRAC_BITS = 16;
   localparam int NELEM     = DIM * DIM;
   localparam int IDX_W     = $clog2(NELEM);
   localparam int DATA_W    = 32;
   localparam int OP_W      = 3;

   localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd4;

   typedef struct packed {
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;
      logic [IDX_W-1:0]         element_index;
      logic                     final_element;
      logic [OP_W-1:0]          op_code;
      logic signed [DATA_W-1:0] scalar_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [IDX_W-1:0]         result_index;
      logic                     last_result;
      logic                     divide_by_zero;
      logic                     saturated;
   } rsp_type;

endpackage

// ===== rtl/core/matrix4_arith_unit.sv =====
// matrix arithmetic unit: element stores, multiply-accumulate sequencer and serial divider
//
//  channel  dir  handshake            beat payload
//  req      in   req_valid/req_stall  m4au_pkg::req_type, one element pair per beat
//  rsp      out  rsp_valid/rsp_stall  m4au_pkg::rsp_type, one result element per beat
//
// one load beat a cycle while idle; after the final beat the result elements follow in order
// per element: add, subtract and scale take a single term; matrix product sums DIM terms, with
//   one read a cycle from each store feeding the multiply-accumulate loop
// divide runs each element through the one-bit restoring divider;
//   a zero divisor skips the divider and goes straight to signing and saturating the quotient
// reset clears the sequencer and the output valid; the stores are undefined until written
// a stalled result beat holds the sequencer in its finish state with loads stalled;
//   loads are taken again once the last element sits in the output register
`include "matrix4_arith_unit_macros.svh"

module matrix4_arith_unit #(
   parameter int FRAC_BITS = m4au_pkg::FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  m4au_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output m4au_pkg::rsp_type rsp_data
);

   localparam int DIM    = m4au_pkg::DIM;
   localparam int NELEM  = m4au_pkg::NELEM;
   localparam int IDX_W  = m4au_pkg::IDX_W;
   localparam int DATA_W = m4au_pkg::DATA_W;
   localparam int OP_W   = m4au_pkg::OP_W;
   localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int STEP_W = $clog2(DIM + 2);
   localparam int PROD_W = 2 * DATA_W;
   // four full products plus headroom for the rounding add
   localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
   // dividend magnitude is |left| shifted up by the fraction width, plus half the divisor
   localparam int NUM_W  = DATA_W + FRAC_BITS;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [NUM_W-1:0]  Q_MAX_POS = NUM_W'(DATA_MAX);
   localparam logic [NUM_W-1:0]  Q_MAX_NEG = NUM_W'(DATA_MIN);
   localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   // sequencer states
   localparam logic [2:0] S_LOAD = 3'd0;   // taking element beats
   localparam logic [2:0] S_MAC  = 3'd1;   // read, multiply, accumulate
   localparam logic [2:0] S_DIV  = 3'd2;   // restoring divider iterations
   localparam logic [2:0] S_FIN  = 3'd3;   // round and saturate accumulator
   localparam logic [2:0] S_DFIN = 3'd4;   // sign and saturate quotient

   // element stores, one synchronous read port each
   logic [DATA_W-1:0] left_mem  [NELEM];
   logic [DATA_W-1:0] right_mem [NELEM];

   logic [2:0]               state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [DIM_W-1:0]         row_ff, row_in;
   logic [DIM_W-1:0]         col_ff, col_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [DATA_W-1:0] scal_ff, scal_in;
   logic signed [DATA_W-1:0] rd_l_ff, rd_r_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [NUM_W-1:0]         num_ff, num_in;
   logic [DATA_W-1:0]        rem_ff, rem_in;
   logic [DATA_W-1:0]        dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic                     lneg_ff, lneg_in;
   logic                     lzero_ff, lzero_in;
   logic [CNT_W-1:0]         div_cnt_ff, div_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   m4au_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     req_accept;
   logic                     store_hit;
   logic [IDX_W-1:0]         l_addr, r_addr;
   logic [DIM_W-1:0]         k_idx;
   logic [STEP_W-1:0]        terms;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [DATA_W:0]   addsub;
   logic signed [PROD_W-1:0] term_value;
   logic [DATA_W-1:0]        l_mag, s_mag;
   logic                     scal_zero;
   logic signed [ACC_W-1:0]  fin_rnd, fin_sh;
   logic [ACC_W-DATA_W:0]    fin_hi;
   logic                     fin_ok;
   logic [DATA_W-1:0]        fin_value, div_value, res_value;
   logic                     fin_sat, div_sat, res_sat;
   logic [DATA_W:0]          rem_sh;
   logic                     rem_ge;
   logic                     out_free;
   logic                     commit;
   logic                     last_elem;

   // load beats only while the sequencer is idle
   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign store_hit  = ({1'b0, req_data.element_index} < (IDX_W + 1)'(NELEM));

   always_ff @(posedge clock) begin
      if (req_accept && store_hit) begin
         left_mem[req_data.element_index]  <= req_data.left_value;
         right_mem[req_data.element_index] <= req_data.right_value;
      end
   end

   // read addresses: the product walks a row of left against a column of right
   assign k_idx = DIM_W'(step_ff);
   always_comb begin
      if (op_ff == m4au_pkg::OP_MUL) begin
         l_addr = IDX_W'(row_ff * DIM + k_idx);
         r_addr = IDX_W'(k_idx * DIM + col_ff);
      end else begin
         l_addr = IDX_W'(row_ff * DIM + col_ff);
         r_addr = IDX_W'(row_ff * DIM + col_ff);
      end
   end

   always_ff @(posedge clock) begin
      rd_l_ff <= left_mem[l_addr];
      rd_r_ff <= right_mem[r_addr];
   end

   // one term of the sum: a full product, or an exact add/sub lifted to the product scale
   assign terms  = (op_ff == m4au_pkg::OP_MUL) ? STEP_W'(DIM) : STEP_W'(1);
   assign mul_b  = (op_ff == m4au_pkg::OP_SCALE) ? scal_ff : rd_r_ff;
   assign mul_p  = rd_l_ff * mul_b;
   assign addsub = (op_ff == m4au_pkg::OP_SUB) ?
                   ({rd_l_ff[DATA_W-1], rd_l_ff} - {rd_r_ff[DATA_W-1], rd_r_ff}) :
                   ({rd_l_ff[DATA_W-1], rd_l_ff} + {rd_r_ff[DATA_W-1], rd_r_ff});
   assign term_value = (op_ff == m4au_pkg::OP_ADD || op_ff == m4au_pkg::OP_SUB) ?
                       (PROD_W'(addsub) <<< FRAC_BITS) : mul_p;

   // magnitudes for the divider
   assign l_mag     = rd_l_ff[DATA_W-1] ? (~rd_l_ff + 1'b1) : rd_l_ff;
   assign s_mag     = scal_ff[DATA_W-1] ? (~scal_ff + 1'b1) : scal_ff;
   assign scal_zero = (scal_ff == '0);

   // round half up at the fraction point, then clip to the data range
   assign fin_rnd   = acc_ff + RND_HALF;
   assign fin_sh    = fin_rnd >>> FRAC_BITS;
   assign fin_hi    = fin_sh[ACC_W-1:DATA_W-1];
   assign fin_ok    = (&fin_hi) || !(|fin_hi);
   assign fin_sat   = !fin_ok;
   assign fin_value = fin_ok ? fin_sh[DATA_W-1:0] :
                      (fin_sh[ACC_W-1] ? DATA_MIN : DATA_MAX);

   // quotient sign and clip; a zero divisor saturates by the sign of the element, zero gives zero
   always_comb begin
      div_value = num_ff[DATA_W-1:0];
      div_sat   = 1'b0;
      if (scal_zero) begin
         if (lzero_ff) begin
            div_value = '0;
         end else if (lneg_ff) begin
            div_value = DATA_MIN;
            div_sat   = 1'b1;
         end else begin
            div_value = DATA_MAX;
            div_sat   = 1'b1;
         end
      end else if (neg_ff) begin
         if (num_ff > Q_MAX_NEG) begin
            div_value = DATA_MIN;
            div_sat   = 1'b1;
         end else begin
            div_value = ~num_ff[DATA_W-1:0] + 1'b1;
         end
      end else if (num_ff > Q_MAX_POS) begin
         div_value = DATA_MAX;
         div_sat   = 1'b1;
      end
   end

   // restoring divider step, one quotient bit a cycle shifted into the dividend
   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign rem_ge = (rem_sh >= {1'b0, dvs_ff});

   // output slot free when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = out_free && (state_ff == S_FIN || state_ff == S_DFIN);
   assign last_elem = (row_ff == DIM_W'(DIM - 1)) && (col_ff == DIM_W'(DIM - 1));
   assign res_value = (state_ff == S_DFIN) ? div_value : fin_value;
   assign res_sat   = (state_ff == S_DFIN) ? div_sat : fin_sat;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      op_in        = op_ff;
      scal_in      = scal_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      lneg_in      = lneg_ff;
      lzero_in     = lzero_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_LOAD: begin
            // op code and scalar come from the final beat
            if (req_accept && req_data.final_element &&
                req_data.op_code <= m4au_pkg::OP_DIV) begin
               op_in    = req_data.op_code;
               scal_in  = req_data.scalar_value;
               row_in   = '0;
               col_in   = '0;
               step_in  = '0;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == '0) begin
               acc_in = '0;
            end
            if (op_ff == m4au_pkg::OP_DIV && step_ff == STEP_W'(1)) begin
               num_in     = {l_mag, {FRAC_BITS{1'b0}}} + NUM_W'(s_mag >> 1);
               dvs_in     = s_mag;
               rem_in     = '0;
               div_cnt_in = '0;
               neg_in     = rd_l_ff[DATA_W-1] ^ scal_ff[DATA_W-1];
               lneg_in    = rd_l_ff[DATA_W-1];
               lzero_in   = (rd_l_ff == '0);
               state_in   = scal_zero ? S_DFIN : S_DIV;
            end else begin
               if (step_ff >= STEP_W'(1) && step_ff <= terms) begin
                  prod_in = term_value;
               end
               if (step_ff >= STEP_W'(2)) begin
                  acc_in = acc_ff + ACC_W'(prod_ff);
               end
               if (step_ff == terms + STEP_W'(1)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_DIV: begin
            rem_in     = rem_ge ? DATA_W'(rem_sh - {1'b0, dvs_ff}) : DATA_W'(rem_sh);
            num_in     = {num_ff[NUM_W-2:0], rem_ge};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = S_DFIN;
            end
         end
         S_FIN, S_DFIN: begin
            if (commit) begin
               step_in = '0;
               if (last_elem) begin
                  state_in = S_LOAD;
               end else begin
                  state_in = S_MAC;
                  if (col_ff == DIM_W'(DIM - 1)) begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (commit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.result_value    = res_value;
         rsp_data_in.result_index    = IDX_W'(row_ff * DIM + col_ff);
         rsp_data_in.last_result     = last_elem;
         rsp_data_in.divide_by_zero  = (op_ff == m4au_pkg::OP_DIV) && scal_zero;
         rsp_data_in.saturated       = res_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         step_ff      <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      scal_ff     <= scal_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      lneg_ff     <= lneg_in;
      lzero_ff    <= lzero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // last mark only on the final position
   `M4AU_ASSERT_IMP(a_last_index, clock, reset,
                    rsp_valid_ff && rsp_data_ff.last_result,
                    rsp_data_ff.result_index == IDX_W'(NELEM - 1))

   // a zero divisor gives full scale with saturation or an exact zero
   `M4AU_ASSERT_IMP(a_dz_value, clock, reset,
                    rsp_valid_ff && rsp_data_ff.divide_by_zero,
                    (rsp_data_ff.result_value == DATA_MAX && rsp_data_ff.saturated) ||
                    (rsp_data_ff.result_value == DATA_MIN && rsp_data_ff.saturated) ||
                    (rsp_data_ff.result_value == '0 && !rsp_data_ff.saturated))

   // sequencer returns to loading once the last element is in the output register
   `M4AU_ASSERT_NXT(a_last_to_load, clock, reset, commit && last_elem, state_ff == S_LOAD)

   // divider never runs past its bit count
   `M4AU_ASSERT_IMP(a_div_count, clock, reset, state_ff == S_DIV,
                    div_cnt_ff <= CNT_W'(NUM_W - 1))

endmodule

// ===== test/matrix4_arith_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the matrix arithmetic unit: directed extremes, then random runs
module matrix4_arith_unit_tb;
   import m4au_pkg::*;

   // op codes above divide store the element pair and start nothing
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   // slowest element is a divide; the tail wait covers a couple of those
   localparam int DIV_CYCLES  = DATA_W + FRAC_BITS + 3;
   localparam int TAIL_CYCLES = 2 * DIV_CYCLES;
   // every beat a final divide, every result beat waiting out a long stall, then twice over
   localparam int CYCLE_LIMIT = 430 * NELEM * (DIV_CYCLES + 40) * 2;

   // wide working range for sums of full products, with the 32-bit clip points
   localparam logic signed [79:0] WIDE_MAX = 80'sh7fff_ffff;
   localparam logic signed [79:0] WIDE_MIN = -WIDE_MAX - 80'sd1;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // local copy of both element stores, kept in step with accepted load beats
   logic signed [DATA_W-1:0] left_copy  [NELEM];
   logic signed [DATA_W-1:0] right_copy [NELEM];

   // result beats worked out but not yet seen, oldest first
   rsp_type awaited_results[$];

   int error_count;
   int beats_sent;
   int ops_started;
   int results_checked;

   // idling odds in percent, changed between phases
   int send_idle_pct;
   int stall_pct;

   matrix4_arith_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- arithmetic

   // clip a wide value to the signed word range, flagging when it was clipped
   function automatic logic [DATA_W-1:0] clip_to_word(input logic signed [79:0] v,
                                                      output logic sat);
      sat = 1'b1;
      if (v > WIDE_MAX) return 32'h7fff_ffff;
      if (v < WIDE_MIN) return 32'h8000_0000;
      sat = 1'b0;
      return v[DATA_W-1:0];
   endfunction

   // one rounding step for full-precision products: add half an lsb, shift down
   function automatic logic [DATA_W-1:0] round_to_word(input logic signed [79:0] acc,
                                                       output logic sat);
      logic signed [79:0] half;
      half = 80'sd1 <<< (FRAC_BITS - 1);
      return clip_to_word((acc + half) >>> FRAC_BITS, sat);
   endfunction

   // quotient rounded on its magnitude, ties away from zero, sign applied after
   function automatic logic [DATA_W-1:0] divide_to_word(input logic signed [DATA_W-1:0] l,
                                                        input logic signed [DATA_W-1:0] s,
                                                        output logic sat);
      logic signed [79:0] num, den, quot;
      logic neg;
      // zero divisor: pinned to the end of the range that the element's sign points at, or zero
      if (s == 0) begin
         sat = (l != 0);
         if (l > 0) return 32'h7fff_ffff;
         if (l < 0) return 32'h8000_0000;
         return '0;
      end
      num = l;
      num = num <<< FRAC_BITS;
      den = s;
      neg = (num < 0) != (den < 0);
      if (num < 0) num = -num;
      if (den < 0) den = -den;
      quot = (num + den / 2) / den;
      return clip_to_word(neg ? -quot : quot, sat);
   endfunction

   // update the store copy with one accepted beat and queue the results it starts
   task automatic apply_beat(input req_type beat);
      rsp_type            r;
      logic signed [79:0] acc, a, b;
      logic               sat;
      int                 row, col;
      // a 4-bit index always lands inside the 16 entries
      left_copy[beat.element_index]  = beat.left_value;
      right_copy[beat.element_index] = beat.right_value;
      if (!beat.final_element || beat.op_code > OP_DIV) return;
      ops_started++;
      for (int i = 0; i < NELEM; i++) begin
         a = left_copy[i];
         b = right_copy[i];
         case (beat.op_code)
            OP_ADD: r.result_value = clip_to_word(a + b, sat);
            OP_SUB: r.result_value = clip_to_word(a - b, sat);
            OP_MUL: begin
               // row of the left times column of the right, summed exactly
               acc = '0;
               row = i / DIM;
               col = i % DIM;
               for (int k = 0; k < DIM; k++) begin
                  a = left_copy[row * DIM + k];
                  b = right_copy[k * DIM + col];
                  acc = acc + a * b;
               end
               r.result_value = round_to_word(acc, sat);
            end
            OP_SCALE: begin
               b = beat.scalar_value;
               r.result_value = round_to_word(a * b, sat);
            end
            default: r.result_value = divide_to_word(left_copy[i], beat.scalar_value, sat);
         endcase
         r.result_index   = IDX_W'(i);
         r.last_result    = (i == NELEM - 1);
         r.divide_by_zero = (beat.op_code == OP_DIV) && (beat.scalar_value == 0);
         r.saturated      = sat;
         awaited_results.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic req_type make_beat(input logic [DATA_W-1:0] left,
                                         input logic [DATA_W-1:0] right,
                                         input int idx, input logic fin,
                                         input logic [OP_W-1:0] op,
                                         input logic [DATA_W-1:0] scale_by);
      req_type beat;
      beat.left_value    = left;
      beat.right_value   = right;
      beat.element_index = IDX_W'(idx);
      beat.final_element = fin;
      beat.op_code       = op;
      beat.scalar_value  = scale_by;
      return beat;
   endfunction

   // q16.16 corners: both range ends, zero, one lsb each way, plus and minus one, one half
   function automatic logic [DATA_W-1:0] special_value(input int k);
      case (k % 8)
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         4:       return 32'h0000_0001;
         5:       return 32'h0001_0000;
         6:       return 32'hffff_0000;
         default: return 32'h0000_8000;
      endcase
   endfunction

   // mix of raw words, moderate values that keep products in range, and corners
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      case ($urandom_range(3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         2: v = special_value($urandom_range(7));
         default: begin
            v = $urandom & 32'h0003_ffff;
            if ($urandom_range(1)) v = -v;
         end
      endcase
      return v;
   endfunction

   function automatic logic [DATA_W-1:0] pick_scalar();
      if ($urandom_range(9) == 0) return '0;
      return pick_value();
   endfunction

   function automatic logic [OP_W-1:0] pick_spare_op();
      return OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
   endfunction

   // divide is the slow one, so it gets a smaller share
   function automatic logic [OP_W-1:0] pick_final_op();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20) return OP_ADD;
      if (roll < 40) return OP_SUB;
      if (roll < 60) return OP_MUL;
      if (roll < 80) return OP_SCALE;
      if (roll < 90) return OP_DIV;
      return pick_spare_op();
   endfunction

   // one load beat: optional idle gap, then hold valid until the unit takes it
   task automatic send_beat(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_beat(beat);
      beats_sent++;
   endtask

   // ---------------------------------------------------------------- directed tests

   // fill every entry with corner pairs; the last beat adds, overflowing both ways
   task automatic test_load_and_add();
      for (int i = 0; i < NELEM; i++)
         send_beat(make_beat(special_value(i), special_value(i + i / 8), i,
                             i == NELEM - 1, OP_ADD, '0));
   endtask

   // most negative minus one lsb clips low; max minus min elsewhere clips high
   task automatic test_subtract();
      send_beat(make_beat(32'h8000_0000, 32'h0000_0001, 2, 1'b1, OP_SUB, '0));
   endtask

   // product over stores full of corners, so some sums clip and some do not
   task automatic test_product();
      send_beat(make_beat(32'h0002_0000, 32'h0003_0000, 5, 1'b1, OP_MUL, '0));
   endtask

   // scaling by both ends of the range
   task automatic test_scale();
      send_beat(make_beat(32'h0001_8000, '0, 3, 1'b1, OP_SCALE, 32'h7fff_ffff));
      send_beat(make_beat(32'hffff_8000, '0, 4, 1'b1, OP_SCALE, 32'h8000_0000));
   endtask

   // rounding divide, zero divisor over positive, negative and zero elements,
   // and the negative divisor of least magnitude, which blows most quotients out of range
   task automatic test_divide();
      send_beat(make_beat(32'h0005_0000, '0, 6, 1'b1, OP_DIV, 32'h0003_0000));
      send_beat(make_beat(32'h0000_0000, '0, 7, 1'b1, OP_DIV, 32'h0000_0000));
      send_beat(make_beat(32'h0000_0001, '0, 9, 1'b1, OP_DIV, 32'hffff_ffff));
   endtask

   // spare op codes on a final beat store the pair and produce no results
   task automatic test_unknown_ops();
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         send_beat(make_beat($urandom, $urandom, 11 + op - OP_SPARE_FIRST, 1'b1,
                             OP_W'(op), $urandom));
   endtask

   // ---------------------------------------------------------------- random runs

   // runs of 1 to 16 loads closed by a final beat; loads carry junk op codes
   // and scalars, and some runs close with a spare op code that starts nothing
   task automatic test_random_traffic(input int n_items);
      int              sent, run_len, start, idx;
      logic            walk, fin;
      logic [OP_W-1:0] op;
      sent = 0;
      while (sent < n_items) begin
         run_len = $urandom_range(1, NELEM);
         start   = $urandom_range(NELEM - 1);
         walk    = $urandom_range(1);
         for (int j = 0; j < run_len; j++) begin
            // half the runs walk the indexes in order, the rest jump about
            idx = walk ? (start + j) % NELEM : $urandom_range(NELEM - 1);
            fin = (j == run_len - 1);
            op  = fin ? pick_final_op() : OP_W'($urandom_range(7));
            send_beat(make_beat(pick_value(), pick_value(), idx, fin, op, pick_scalar()));
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- result side

   // receiver back-pressure, one fresh draw per clock
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // each taken result beat against the oldest awaited one, field by field
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result beat with nothing awaited: result_index %0d", rsp_data.result_index);
            error_count++;
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (rsp_data.result_value !== want.result_value) begin
               $error("result_value: expected %0d, got %0d",
                      want.result_value, rsp_data.result_value);
               error_count++;
            end
            if (rsp_data.result_index !== want.result_index) begin
               $error("result_index: expected %0d, got %0d",
                      want.result_index, rsp_data.result_index);
               error_count++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result: expected %0d, got %0d",
                      want.last_result, rsp_data.last_result);
               error_count++;
            end
            if (rsp_data.divide_by_zero !== want.divide_by_zero) begin
               $error("divide_by_zero: expected %0d, got %0d",
                      want.divide_by_zero, rsp_data.divide_by_zero);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d",
                      want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // hang guard
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part with no idling; the first test writes every entry,
      // so no later operation reads an unwritten one
      test_load_and_add();
      test_subtract();
      test_product();
      test_scale();
      test_divide();
      test_unknown_ops();

      // random part over the idling phases
      test_random_traffic(100);
      send_idle_pct = 55;
      test_random_traffic(100);
      send_idle_pct = 0;
      stall_pct     = 55;
      test_random_traffic(100);
      send_idle_pct = 9;
      stall_pct     = 9;
      test_random_traffic(105);
      req_valid <= 1'b0;

      // drain, then watch a while longer for stray result beats
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d load beats, %0d operations and %0d checked result beats",
               beats_sent, ops_started, results_checked);
      $display("corner values and every op code, then random runs under four idling mixes");
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
